// ===== rtl/obsd_pkg.sv =====
// Shared types and codes for the operand byte-stream decoder.
// No dependencies; every other file refers to this package by scoped names.
package obsd_pkg;

	// word queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// operand prefix bytes
	localparam logic [7:0] PFX_REG   = 8'h01;
	localparam logic [7:0] PFX_CONST = 8'h02;
	localparam logic [7:0] PFX_MEM   = 8'h03;

	// register size bytes
	localparam logic [7:0] SZ_8  = 8'h08;
	localparam logic [7:0] SZ_16 = 8'h16;
	localparam logic [7:0] SZ_32 = 8'h32;
	localparam logic [7:0] SZ_64 = 8'h64;

	// scale bytes
	localparam logic [7:0] SC_X1  = 8'h01;
	localparam logic [7:0] SC_X2  = 8'h02;
	localparam logic [7:0] SC_X4  = 8'h04;
	localparam logic [7:0] SC_X8  = 8'h08;
	localparam logic [7:0] SC_X16 = 8'h16;

	// register width codes
	localparam logic [1:0] W_8  = 2'd0;
	localparam logic [1:0] W_16 = 2'd1;
	localparam logic [1:0] W_32 = 2'd2;
	localparam logic [1:0] W_64 = 2'd3;

	// scale codes
	localparam logic [2:0] SCALE_1  = 3'd0;
	localparam logic [2:0] SCALE_2  = 3'd1;
	localparam logic [2:0] SCALE_4  = 3'd2;
	localparam logic [2:0] SCALE_8  = 3'd3;
	localparam logic [2:0] SCALE_16 = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_REG   = 2'd0;
	localparam logic [1:0] KIND_CONST = 2'd1;
	localparam logic [1:0] KIND_MEM   = 2'd2;
	localparam logic [1:0] KIND_ERR   = 2'd3;

	// error codes
	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_PREFIX = 3'd1;
	localparam logic [2:0] ERR_SIZE   = 3'd2;
	localparam logic [2:0] ERR_SCALE  = 3'd3;
	localparam logic [2:0] ERR_PARAM  = 3'd4;

	// back-end phases; unused codes behave as idle
	localparam logic [2:0] PH_IDLE         = 3'd0;
	localparam logic [2:0] PH_REG_SIZE     = 3'd1;
	localparam logic [2:0] PH_REG_INDEX    = 3'd2;
	localparam logic [2:0] PH_CONST_SIGN   = 3'd3;
	localparam logic [2:0] PH_CONST_VALUE  = 3'd4;
	localparam logic [2:0] PH_MEM_SCALE    = 3'd5;
	localparam logic [2:0] PH_PARAM_PREFIX = 3'd6;

	// classified word as queued between front and back
	typedef struct packed {
		logic [7:0] data;
		logic       is_reg;
		logic       is_const;
		logic       is_mem;
		logic       size_ok;
		logic [1:0] size_code;
		logic       scale_ok;
		logic [2:0] scale_code;
		logic       nonzero;
	} cls_t;

	// one decoded result
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  reg_width;
		logic [7:0]  reg_index;
		logic [63:0] cvalue;
		logic        csigned;
		logic [2:0]  scale;
		logic        in_mem;
		logic [2:0]  err;
		logic        last;
	} res_t;

endpackage

// ===== rtl/operand_byte_stream_decoder_unit.sv =====
// Operand byte-stream decoder, top level: front classifier, word queue, back decoder.
// Depends on obsd_pkg, obsd_front, obsd_fifo and obsd_back.
//
// One operand byte is accepted per cycle on the in_valid/in_ready channel while the
// queue has room. The front classifies each byte and drops it into a four-word queue;
// the back-end state machine consumes one queued word per cycle while no result waits
// on a stalled output, and registers a result when a component completes, after the byte
// that completes it has passed the queue. The sustained rate is one byte per cycle while
// results are taken, set by the back-end state machine stepping once per word; a stalled
// output stops the back end only, and input keeps flowing until the queue fills. Errors
// give one result with last set and the decoder returns to idle.
module operand_byte_stream_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  item_kind,
	output logic [1:0]  register_width,
	output logic [7:0]  reg_number,
	output logic [63:0] constant_value,
	output logic        constant_signed,
	output logic [2:0]  scale_code,
	output logic        in_memory,
	output logic [2:0]  error_code,
	output logic        last
);

	obsd_pkg::cls_t q_wdata;
	obsd_pkg::cls_t q_rdata;
	obsd_pkg::res_t res;
	logic           q_push;
	logic           q_pop;
	logic           q_full;
	logic           q_empty;

	obsd_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	obsd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	obsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign item_kind       = res.kind;
	assign register_width  = res.reg_width;
	assign reg_number      = res.reg_index;
	assign constant_value  = res.cvalue;
	assign constant_signed = res.csigned;
	assign scale_code      = res.scale;
	assign in_memory       = res.in_mem;
	assign error_code      = res.err;
	assign last            = res.last;

endmodule

// ===== rtl/obsd_front.sv =====
// Front end: takes input words and classifies prefix, size and scale codes.
// Depends on obsd_pkg; feeds obsd_fifo.
module obsd_front (
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    data_byte,
	input  logic          q_full,
	output logic          q_push,
	output obsd_pkg::cls_t q_wdata
);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_wdata          = '0;
		q_wdata.data     = data_byte;
		q_wdata.is_reg   = (data_byte == obsd_pkg::PFX_REG);
		q_wdata.is_const = (data_byte == obsd_pkg::PFX_CONST);
		q_wdata.is_mem   = (data_byte == obsd_pkg::PFX_MEM);
		q_wdata.nonzero  = (data_byte != 8'h00);

		q_wdata.size_ok = 1'b1;
		unique case (data_byte)
			obsd_pkg::SZ_8:  q_wdata.size_code = obsd_pkg::W_8;
			obsd_pkg::SZ_16: q_wdata.size_code = obsd_pkg::W_16;
			obsd_pkg::SZ_32: q_wdata.size_code = obsd_pkg::W_32;
			obsd_pkg::SZ_64: q_wdata.size_code = obsd_pkg::W_64;
			default: begin
				q_wdata.size_code = obsd_pkg::W_8;
				q_wdata.size_ok   = 1'b0;
			end
		endcase

		q_wdata.scale_ok = 1'b1;
		unique case (data_byte)
			obsd_pkg::SC_X1:  q_wdata.scale_code = obsd_pkg::SCALE_1;
			obsd_pkg::SC_X2:  q_wdata.scale_code = obsd_pkg::SCALE_2;
			obsd_pkg::SC_X4:  q_wdata.scale_code = obsd_pkg::SCALE_4;
			obsd_pkg::SC_X8:  q_wdata.scale_code = obsd_pkg::SCALE_8;
			obsd_pkg::SC_X16: q_wdata.scale_code = obsd_pkg::SCALE_16;
			default: begin
				q_wdata.scale_code = obsd_pkg::SCALE_1;
				q_wdata.scale_ok   = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/obsd_fifo.sv =====
// Short word queue between the front and back ends.
// Depends on obsd_pkg for depth and entry type.
module obsd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  obsd_pkg::cls_t wdata,
	input  logic           pop,
	output obsd_pkg::cls_t rdata,
	output logic           full,
	output logic           empty
);

	obsd_pkg::cls_t                   mem_q [obsd_pkg::QDEPTH];
	logic [obsd_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [obsd_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [obsd_pkg::QCNT_W-1:0]      cnt_q;

	localparam logic [obsd_pkg::QPTR_W-1:0] PTR_LAST = obsd_pkg::QPTR_W'(obsd_pkg::QDEPTH - 1);
	localparam logic [obsd_pkg::QCNT_W-1:0] CNT_FULL = obsd_pkg::QCNT_W'(obsd_pkg::QDEPTH);

	assign full  = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |-> !push)
		else $error("word queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("word queue read while empty");

endmodule

// ===== rtl/obsd_back.sv =====
// Back end: operand state machine, constant assembly and result register.
// Depends on obsd_pkg; draws classified words from obsd_fifo.
module obsd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  obsd_pkg::cls_t  q_rdata,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output obsd_pkg::res_t  res
);

	logic [2:0]  phase_q, phase_d;
	logic [63:0] value_q, value_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [1:0]  left_q, left_d, left_dec;
	logic        mem_q, mem_d;
	logic        sign_q, sign_d;
	logic [1:0]  width_q, width_d;

	logic            out_valid_q;
	obsd_pkg::res_t  res_q;
	obsd_pkg::res_t  res_d;
	logic            has_res;
	logic            finish;
	logic            clr;

	assign q_pop     = !q_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign left_dec  = left_q - 2'd1;

	always_comb begin
		phase_d = phase_q;
		value_d = value_q;
		cnt_d   = cnt_q;
		left_d  = left_q;
		mem_d   = mem_q;
		sign_d  = sign_q;
		width_d = width_q;
		res_d   = '0;
		has_res = 1'b0;
		finish  = 1'b0;
		clr     = 1'b0;

		if (q_pop) begin
			unique case (phase_q)
				obsd_pkg::PH_REG_SIZE: begin
					if (q_rdata.size_ok) begin
						width_d = q_rdata.size_code;
						phase_d = obsd_pkg::PH_REG_INDEX;
					end else begin
						has_res      = 1'b1;
						res_d.kind   = obsd_pkg::KIND_ERR;
						res_d.in_mem = mem_q;
						res_d.err    = obsd_pkg::ERR_SIZE;
						res_d.last   = 1'b1;
						clr          = 1'b1;
					end
				end
				obsd_pkg::PH_REG_INDEX: begin
					has_res         = 1'b1;
					res_d.kind      = obsd_pkg::KIND_REG;
					res_d.reg_width = width_q;
					res_d.reg_index = q_rdata.data;
					finish          = 1'b1;
				end
				obsd_pkg::PH_CONST_SIGN: begin
					sign_d  = q_rdata.nonzero;
					value_d = '0;
					cnt_d   = '0;
					phase_d = obsd_pkg::PH_CONST_VALUE;
				end
				obsd_pkg::PH_CONST_VALUE: begin
					// little-endian: each word enters at the top and moves down
					value_d = {q_rdata.data, value_q[63:8]};
					if (cnt_q != 3'd7) begin
						cnt_d = cnt_q + 3'd1;
					end else begin
						has_res       = 1'b1;
						res_d.kind    = obsd_pkg::KIND_CONST;
						res_d.cvalue  = value_d;
						res_d.csigned = sign_q;
						cnt_d         = '0;
						value_d       = '0;
						sign_d        = 1'b0;
						finish        = 1'b1;
					end
				end
				obsd_pkg::PH_MEM_SCALE: begin
					has_res = 1'b1;
					if (q_rdata.scale_ok) begin
						res_d.kind   = obsd_pkg::KIND_MEM;
						res_d.scale  = q_rdata.scale_code;
						res_d.in_mem = 1'b1;
						left_d       = 2'd3;
						phase_d      = obsd_pkg::PH_PARAM_PREFIX;
					end else begin
						res_d.kind   = obsd_pkg::KIND_ERR;
						res_d.in_mem = mem_q;
						res_d.err    = obsd_pkg::ERR_SCALE;
						res_d.last   = 1'b1;
						clr          = 1'b1;
					end
				end
				obsd_pkg::PH_PARAM_PREFIX: begin
					if (q_rdata.is_reg) begin
						phase_d = obsd_pkg::PH_REG_SIZE;
					end else if (q_rdata.is_const) begin
						phase_d = obsd_pkg::PH_CONST_SIGN;
					end else begin
						has_res      = 1'b1;
						res_d.kind   = obsd_pkg::KIND_ERR;
						res_d.in_mem = mem_q;
						res_d.err    = obsd_pkg::ERR_PARAM;
						res_d.last   = 1'b1;
						clr          = 1'b1;
					end
				end
				default: begin
					// idle starts from a clean state
					value_d = '0;
					cnt_d   = '0;
					left_d  = '0;
					mem_d   = 1'b0;
					sign_d  = 1'b0;
					width_d = '0;
					phase_d = obsd_pkg::PH_IDLE;
					if (q_rdata.is_reg) begin
						phase_d = obsd_pkg::PH_REG_SIZE;
					end else if (q_rdata.is_const) begin
						phase_d = obsd_pkg::PH_CONST_SIGN;
					end else if (q_rdata.is_mem) begin
						mem_d   = 1'b1;
						phase_d = obsd_pkg::PH_MEM_SCALE;
					end else begin
						has_res    = 1'b1;
						res_d.kind = obsd_pkg::KIND_ERR;
						res_d.err  = obsd_pkg::ERR_PREFIX;
						res_d.last = 1'b1;
					end
				end
			endcase

			if (finish) begin
				if (mem_q) begin
					res_d.in_mem = 1'b1;
					left_d       = left_dec;
					if (left_dec == 2'd0) begin
						res_d.last = 1'b1;
						clr        = 1'b1;
					end else begin
						phase_d = obsd_pkg::PH_PARAM_PREFIX;
					end
				end else begin
					res_d.last = 1'b1;
					clr        = 1'b1;
				end
			end

			if (clr) begin
				phase_d = obsd_pkg::PH_IDLE;
				value_d = '0;
				cnt_d   = '0;
				left_d  = '0;
				mem_d   = 1'b0;
				sign_d  = 1'b0;
				width_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= obsd_pkg::PH_IDLE;
			value_q     <= '0;
			cnt_q       <= '0;
			left_q      <= '0;
			mem_q       <= 1'b0;
			sign_q      <= 1'b0;
			width_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			value_q <= value_d;
			cnt_q   <= cnt_d;
			left_q  <= left_d;
			mem_q   <= mem_d;
			sign_q  <= sign_d;
			width_q <= width_d;
			if (q_pop && has_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && has_res) begin
			res_q <= res_d;
		end
	end

	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!out_valid_q || out_ready))
		else $error("word taken while a result is stuck");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && has_res && res_d.last) |=> (phase_q == obsd_pkg::PH_IDLE && !mem_q))
		else $error("operand ended but decoder not idle");

endmodule

// ===== sim/operand_decode_checker.sv =====
// Result checker for the operand byte-stream decoder: predicts each result from the
// accepted words and compares it with what leaves the block. Depends on obsd_pkg.
module operand_decode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  item_kind,
	input  logic [1:0]  register_width,
	input  logic [7:0]  reg_number,
	input  logic [63:0] constant_value,
	input  logic        constant_signed,
	input  logic [2:0]  scale_code,
	input  logic        in_memory,
	input  logic [2:0]  error_code,
	input  logic        last,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// decoder state as the predictor sees it
	logic [2:0]  phase;
	logic [63:0] value_shift;
	logic [2:0]  byte_count;
	logic [1:0]  params_left;
	logic        memory_mode;
	logic        sign_seen;
	logic [1:0]  width_code;

	obsd_pkg::res_t predicted_results [$];
	int             fail_cnt = 0;

	assign mismatches = fail_cnt;

	task automatic clear_decoder();
		phase       = obsd_pkg::PH_IDLE;
		value_shift = '0;
		byte_count  = '0;
		params_left = '0;
		memory_mode = 1'b0;
		sign_seen   = 1'b0;
		width_code  = obsd_pkg::W_8;
	endtask

	task automatic raise_error(input logic [2:0] code, output obsd_pkg::res_t r);
		r        = '0;
		r.kind   = obsd_pkg::KIND_ERR;
		r.in_mem = memory_mode;
		r.err    = code;
		r.last   = 1'b1;
		clear_decoder();
	endtask

	// register or constant done: inside memory, count down the parameters
	task automatic close_component(inout obsd_pkg::res_t r);
		if (memory_mode) begin
			r.in_mem    = 1'b1;
			params_left = params_left - 2'd1;
			if (params_left == 2'd0) begin
				r.last = 1'b1;
				clear_decoder();
			end else begin
				phase = obsd_pkg::PH_PARAM_PREFIX;
			end
		end else begin
			r.last = 1'b1;
			clear_decoder();
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, output bit produces,
			output obsd_pkg::res_t r);
		bit bad;
		r        = '0;
		produces = 1'b0;
		bad      = 1'b0;
		case (phase)
			obsd_pkg::PH_REG_SIZE: begin
				case (b)
					obsd_pkg::SZ_8:  width_code = obsd_pkg::W_8;
					obsd_pkg::SZ_16: width_code = obsd_pkg::W_16;
					obsd_pkg::SZ_32: width_code = obsd_pkg::W_32;
					obsd_pkg::SZ_64: width_code = obsd_pkg::W_64;
					default:         bad = 1'b1;
				endcase
				if (bad) begin
					raise_error(obsd_pkg::ERR_SIZE, r);
					produces = 1'b1;
				end else begin
					phase = obsd_pkg::PH_REG_INDEX;
				end
			end
			obsd_pkg::PH_REG_INDEX: begin
				r.kind      = obsd_pkg::KIND_REG;
				r.reg_width = width_code;
				r.reg_index = b;
				close_component(r);
				produces = 1'b1;
			end
			obsd_pkg::PH_CONST_SIGN: begin
				sign_seen   = (b != 8'h00);
				value_shift = '0;
				byte_count  = '0;
				phase       = obsd_pkg::PH_CONST_VALUE;
			end
			obsd_pkg::PH_CONST_VALUE: begin
				value_shift = value_shift | (64'(b) << (8 * byte_count));
				if (byte_count != 3'd7) begin
					byte_count = byte_count + 3'd1;
				end else begin
					r.kind      = obsd_pkg::KIND_CONST;
					r.cvalue    = value_shift;
					r.csigned   = sign_seen;
					byte_count  = '0;
					value_shift = '0;
					sign_seen   = 1'b0;
					close_component(r);
					produces = 1'b1;
				end
			end
			obsd_pkg::PH_MEM_SCALE: begin
				case (b)
					obsd_pkg::SC_X1:  r.scale = obsd_pkg::SCALE_1;
					obsd_pkg::SC_X2:  r.scale = obsd_pkg::SCALE_2;
					obsd_pkg::SC_X4:  r.scale = obsd_pkg::SCALE_4;
					obsd_pkg::SC_X8:  r.scale = obsd_pkg::SCALE_8;
					obsd_pkg::SC_X16: r.scale = obsd_pkg::SCALE_16;
					default:          bad = 1'b1;
				endcase
				if (bad) begin
					raise_error(obsd_pkg::ERR_SCALE, r);
				end else begin
					r.kind      = obsd_pkg::KIND_MEM;
					r.in_mem    = 1'b1;
					params_left = 2'd3;
					phase       = obsd_pkg::PH_PARAM_PREFIX;
				end
				produces = 1'b1;
			end
			obsd_pkg::PH_PARAM_PREFIX: begin
				if (b == obsd_pkg::PFX_REG) begin
					phase = obsd_pkg::PH_REG_SIZE;
				end else if (b == obsd_pkg::PFX_CONST) begin
					phase = obsd_pkg::PH_CONST_SIGN;
				end else begin
					raise_error(obsd_pkg::ERR_PARAM, r);
					produces = 1'b1;
				end
			end
			default: begin
				clear_decoder();
				if (b == obsd_pkg::PFX_REG) begin
					phase = obsd_pkg::PH_REG_SIZE;
				end else if (b == obsd_pkg::PFX_CONST) begin
					phase = obsd_pkg::PH_CONST_SIGN;
				end else if (b == obsd_pkg::PFX_MEM) begin
					memory_mode = 1'b1;
					phase       = obsd_pkg::PH_MEM_SCALE;
				end else begin
					raise_error(obsd_pkg::ERR_PREFIX, r);
					produces = 1'b1;
				end
			end
		endcase
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] seen);
		if (seen !== want) begin
			$display("%0t ns: %s expected %0h actual %0h", $time, name, want, seen);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		obsd_pkg::res_t want;
		obsd_pkg::res_t pred;
		bit             produces;
		if (!arst_n) begin
			clear_decoder();
			predicted_results.delete();
			outstanding <= 0;
		end else begin
			// pop before push: a result never leaves in the cycle its word arrives
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t ns: result with nothing predicted, expected none actual kind %0d",
						$time, item_kind);
					fail_cnt++;
				end else begin
					want = predicted_results.pop_front();
					compare_field("item_kind", 64'(want.kind), 64'(item_kind));
					compare_field("register_width", 64'(want.reg_width),
						64'(register_width));
					compare_field("reg_number", 64'(want.reg_index), 64'(reg_number));
					compare_field("constant_value", want.cvalue, constant_value);
					compare_field("constant_signed", 64'(want.csigned),
						64'(constant_signed));
					compare_field("scale_code", 64'(want.scale), 64'(scale_code));
					compare_field("in_memory", 64'(want.in_mem), 64'(in_memory));
					compare_field("error_code", 64'(want.err), 64'(error_code));
					compare_field("last", 64'(want.last), 64'(last));
				end
			end
			if (in_valid && in_ready) begin
				decode_byte(data_byte, produces, pred);
				if (produces)
					predicted_results.insert(predicted_results.size(), pred);
			end
			outstanding <= predicted_results.size();
		end
	end

endmodule

// ===== sim/tb_operand_byte_stream_decoder_unit.sv =====
// Testbench top for operand_byte_stream_decoder_unit: builds the operand word stream,
// drives both channels with random idling and gives the verdict.
// Depends on obsd_pkg, the decoder RTL and operand_decode_checker.
module tb_operand_byte_stream_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {CS_TARGET, CS_SIZE, CS_SCALE, CS_PARAM} code_set_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [1:0]  item_kind;
	logic [1:0]  register_width;
	logic [7:0]  reg_number;
	logic [63:0] constant_value;
	logic        constant_signed;
	logic [2:0]  scale_code;
	logic        in_memory;
	logic [2:0]  error_code;
	logic        last;
	int          mismatches;
	int          outstanding;

	logic [7:0] op_bytes [$];
	int         pause_at [$];
	int         random_ops = 0;

	operand_byte_stream_decoder_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.item_kind(item_kind), .register_width(register_width),
		.reg_number(reg_number), .constant_value(constant_value),
		.constant_signed(constant_signed), .scale_code(scale_code),
		.in_memory(in_memory), .error_code(error_code), .last(last)
	);

	operand_decode_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.item_kind(item_kind), .register_width(register_width),
		.reg_number(reg_number), .constant_value(constant_value),
		.constant_signed(constant_signed), .scale_code(scale_code),
		.in_memory(in_memory), .error_code(error_code), .last(last),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit known_code(code_set_t set, logic [7:0] b);
		case (set)
			CS_TARGET: return b == obsd_pkg::PFX_REG || b == obsd_pkg::PFX_CONST ||
					b == obsd_pkg::PFX_MEM;
			CS_SIZE:   return b == obsd_pkg::SZ_8 || b == obsd_pkg::SZ_16 ||
					b == obsd_pkg::SZ_32 || b == obsd_pkg::SZ_64;
			CS_SCALE:  return b == obsd_pkg::SC_X1 || b == obsd_pkg::SC_X2 ||
					b == obsd_pkg::SC_X4 || b == obsd_pkg::SC_X8 ||
					b == obsd_pkg::SC_X16;
			default:   return b == obsd_pkg::PFX_REG || b == obsd_pkg::PFX_CONST;
		endcase
	endfunction

	function automatic logic [7:0] unknown_code(code_set_t set);
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (known_code(set, b));
		return b;
	endfunction

	function automatic logic [7:0] rand_size();
		case ($urandom_range(0, 3))
			0:       return obsd_pkg::SZ_8;
			1:       return obsd_pkg::SZ_16;
			2:       return obsd_pkg::SZ_32;
			default: return obsd_pkg::SZ_64;
		endcase
	endfunction

	function automatic logic [7:0] rand_scale();
		case ($urandom_range(0, 4))
			0:       return obsd_pkg::SC_X1;
			1:       return obsd_pkg::SC_X2;
			2:       return obsd_pkg::SC_X4;
			3:       return obsd_pkg::SC_X8;
			default: return obsd_pkg::SC_X16;
		endcase
	endfunction

	function automatic logic [7:0] rand_sign();
		if ($urandom_range(0, 1))
			return 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [63:0] rand_value();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return 64'h8000_0000_0000_0000;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic add_byte(input logic [7:0] b);
		op_bytes.insert(op_bytes.size(), b);
	endtask

	// an unknown size ends the register: no index word follows
	task automatic push_register(input logic [7:0] sz, input logic [7:0] idx);
		add_byte(obsd_pkg::PFX_REG);
		add_byte(sz);
		if (known_code(CS_SIZE, sz))
			add_byte(idx);
	endtask

	task automatic push_constant(input logic [7:0] sgn, input logic [63:0] v);
		add_byte(obsd_pkg::PFX_CONST);
		add_byte(sgn);
		for (int k = 0; k < 8; k++)
			add_byte(v[8*k +: 8]);
	endtask

	task automatic push_param();
		if ($urandom_range(0, 1))
			push_register(rand_size(), 8'($urandom_range(0, 255)));
		else
			push_constant(rand_sign(), rand_value());
	endtask

	// bad_slot below 3 spoils that parameter, by prefix or by register size
	task automatic push_memory(input logic [7:0] scale, input int bad_slot, input bit by_size);
		add_byte(obsd_pkg::PFX_MEM);
		add_byte(scale);
		if (known_code(CS_SCALE, scale)) begin
			for (int k = 0; k < 3; k++) begin
				if (k == bad_slot) begin
					if (by_size)
						push_register(unknown_code(CS_SIZE), 8'h00);
					else
						add_byte(unknown_code(CS_PARAM));
					break;
				end
				push_param();
			end
		end
	endtask

	task automatic push_random_operand();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			push_register(rand_size(), 8'($urandom_range(0, 255)));
		end else if (pick < 52) begin
			push_constant(rand_sign(), rand_value());
		end else if (pick < 86) begin
			push_memory(rand_scale(), int'($urandom_range(0, 39)),
				1'($urandom_range(0, 1)));
		end else begin
			case ($urandom_range(0, 3))
				0:       add_byte(unknown_code(CS_TARGET));
				1:       push_register(unknown_code(CS_SIZE), 8'h00);
				2:       push_memory(unknown_code(CS_SCALE), 3, 1'b0);
				// lone word: may open an operand that the next one's words finish
				default: add_byte(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// result side: fresh stall per result, with calm stretches
	initial begin : sink
		int stall;
		bit rx_calm;
		rx_calm = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, 17);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : source
		int directed_len;
		int gap;
		int drain;
		bit tx_calm;
		tx_calm = 1'b0;

		push_register(obsd_pkg::SZ_8, 8'h00);
		push_register(obsd_pkg::SZ_16, 8'hFF);
		push_register(obsd_pkg::SZ_32, 8'h80);
		push_register(obsd_pkg::SZ_64, 8'h7F);
		push_constant(8'h00, 64'h0);
		push_constant(8'hFF, '1);
		push_constant(8'h01, 64'h8000_0000_0000_0001);
		push_memory(obsd_pkg::SC_X1, 3, 1'b0);
		push_memory(obsd_pkg::SC_X2, 3, 1'b0);
		push_memory(obsd_pkg::SC_X4, 3, 1'b0);
		push_memory(obsd_pkg::SC_X8, 3, 1'b0);
		push_memory(obsd_pkg::SC_X16, 3, 1'b0);
		add_byte(8'h00);
		add_byte(8'hFF);
		push_register(8'h00, 8'h00);
		push_memory(8'h03, 3, 1'b0);
		push_memory(obsd_pkg::SC_X1, 0, 1'b0);
		push_memory(obsd_pkg::SC_X2, 1, 1'b1);
		push_memory(obsd_pkg::SC_X4, 2, 1'b0);
		directed_len = op_bytes.size();
		pause_at.insert(pause_at.size(), directed_len);
		while (op_bytes.size() < 1250) begin
			if (pause_at.size() == 1 && op_bytes.size() >= 625)
				pause_at.insert(pause_at.size(), op_bytes.size());
			push_random_operand();
			random_ops++;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < op_bytes.size(); i++) begin
			// let the block run dry before carrying on
			if (pause_at.size() != 0 && pause_at[0] == i) begin
				void'(pause_at.pop_front());
				in_valid <= 1'b0;
				@(posedge clk);
				while (outstanding != 0) @(posedge clk);
			end
			if ($urandom_range(0, 47) == 0)
				tx_calm = !tx_calm;
			gap = tx_calm ? 0 : $urandom_range(0, 17);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid  <= 1'b1;
			data_byte <= op_bytes[i];
			@(posedge clk);
			while (!in_ready) @(posedge clk);
		end
		in_valid <= 1'b0;

		drain = 0;
		@(posedge clk);
		while (outstanding != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);

		$display("sent %0d operand words: registers of each size, constants, memory at every",
			op_bytes.size());
		$display("scale, each error kind, then %0d random operands and broken sequences",
			random_ops);
		if (mismatches == 0 && outstanding == 0) begin
			$display("operand_byte_stream_decoder_unit: match");
		end else begin
			if (outstanding != 0)
				$display("%0t ns: %0d predicted results never arrived", $time, outstanding);
			$display("operand_byte_stream_decoder_unit: mismatch");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("timeout at %0t ns", $time);
		$display("operand_byte_stream_decoder_unit: mismatch");
		$finish;
	end

endmodule
